FILE: hw/rtl/fskm_pkg.sv
// Shared types, constants and the sine table generator for the FSK tone modulator.
package fskm_pkg;

    localparam int PHASE_BITS_DEF     = 24;
    localparam int SINE_ADDR_BITS_DEF = 10;
    localparam int SINE_ADDR_MAX      = 14;

    localparam int STEP_W   = 23;
    localparam int LEN_W    = 16;
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [STEP_W-1:0] SPACE_STEP_RST   = 23'd6291456;
    localparam logic [STEP_W-1:0] MARK_STEP_RST    = 23'd6640981;
    localparam logic [LEN_W-1:0]  FRAGMENT_LEN_RST = 16'd480;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPACE_STEP   = 2'd0,
        REG_MARK_STEP    = 2'd1,
        REG_FRAGMENT_LEN = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic                     active;
        logic [SINE_ADDR_MAX-1:0] addr;
        logic                     accepted;
        logic                     need_byte;
    } t_work;

    // One entry of the quarter-wave table: 32767 * sin(pi/2 * k / 2^qb) in Q30 arithmetic.
    function automatic logic [MAG_W-1:0] rom_value(input int unsigned k,
                                                   input int unsigned qb);
        longint unsigned x;
        longint unsigned th;
        longint unsigned t2;
        longint unsigned r;
        longint unsigned s;
        longint unsigned v;
        longint unsigned one;
        one = 64'd1073741824;
        x   = longint'(k) << (30 - qb);
        th  = (x * 64'd1686629713) >> 30;
        t2  = (th * th) >> 30;
        r   = one;
        r   = one - ((t2 * r) >> 30) / 110;
        r   = one - ((t2 * r) >> 30) / 72;
        r   = one - ((t2 * r) >> 30) / 42;
        r   = one - ((t2 * r) >> 30) / 20;
        r   = one - ((t2 * r) >> 30) / 6;
        s   = (th * r) >> 30;
        v   = (64'd32767 * s + (one >> 1)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[MAG_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/fskm_if.sv
// Handshake channel interfaces for the input, result and configuration sides.
interface fskm_in_if
    import fskm_pkg::*;
    ();
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface fskm_out_if
    import fskm_pkg::*;
    ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_valid;
    logic                       byte_accepted;
    logic                       need_byte;

    modport source (output valid, output sample, output sample_valid,
                    output byte_accepted, output need_byte, input ready);
    modport sink   (input valid, input sample, input sample_valid,
                    input byte_accepted, input need_byte, output ready);
endinterface

interface fskm_cfg_if
    import fskm_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/fskm_front.sv
// Front part: takes items, keeps configuration, phase and bit state, and queues work.
module fskm_front
    import fskm_pkg::*;
#(
    parameter int PHASE_BITS     = PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fskm_in_if.sink      i_in,
    fskm_cfg_if.sink     i_cfg,
    input  logic         i_full,
    output logic         o_push,
    output t_work        o_work
);

    localparam int SUM_W = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;

    logic [STEP_W-1:0]     r_space_step;
    logic [STEP_W-1:0]     r_mark_step;
    logic [LEN_W-1:0]      r_fragment_len;
    logic [PHASE_BITS-1:0] r_phase, n_phase;
    logic [7:0]            r_shifter, n_shifter;
    logic [3:0]            r_bits_rem, n_bits_rem;
    logic [LEN_W-1:0]      r_sib, n_sib;

    logic [LEN_W-1:0]  w_len;
    logic [STEP_W-1:0] w_step;
    logic [SUM_W-1:0]  w_sum;
    logic [LEN_W-1:0]  w_sib_inc;
    logic              w_is_tick;
    logic              w_tick_active;
    logic              w_load_ok;

    assign i_in.ready  = !i_full;
    assign i_cfg.ready = 1'b1;
    assign o_push      = i_in.valid && !i_full;

    assign w_len      = (r_fragment_len == '0) ? LEN_W'(1) : r_fragment_len;
    assign w_step     = r_shifter[7] ? r_mark_step : r_space_step;
    assign w_sum      = SUM_W'(r_phase) + SUM_W'(w_step);
    assign w_sib_inc  = r_sib + LEN_W'(1);
    assign w_is_tick  = (t_cmd'(i_in.cmd) == CMD_TICK);
    assign w_tick_active = w_is_tick && (r_bits_rem != '0);
    assign w_load_ok  = !w_is_tick && (r_bits_rem == '0);

    always_comb begin
        n_phase    = r_phase;
        n_shifter  = r_shifter;
        n_bits_rem = r_bits_rem;
        n_sib      = r_sib;
        if (w_load_ok) begin
            n_shifter  = i_in.data_byte;
            n_bits_rem = BITS_PER_BYTE;
            n_sib      = '0;
        end else if (w_tick_active) begin
            n_phase = w_sum[PHASE_BITS-1:0];
            if (w_sib_inc == '0 || w_sib_inc >= w_len) begin
                n_sib      = '0;
                n_shifter  = {r_shifter[6:0], 1'b0};
                n_bits_rem = r_bits_rem - 4'd1;
            end else begin
                n_sib = w_sib_inc;
            end
        end
    end

    always_comb begin
        o_work.active    = w_tick_active;
        o_work.addr      = SINE_ADDR_MAX'(r_phase[PHASE_BITS-1 -: SINE_ADDR_BITS]);
        o_work.accepted  = w_load_ok;
        o_work.need_byte = (n_bits_rem == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_space_step   <= SPACE_STEP_RST;
            r_mark_step    <= MARK_STEP_RST;
            r_fragment_len <= FRAGMENT_LEN_RST;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_SPACE_STEP:   r_space_step   <= i_cfg.data[STEP_W-1:0];
                REG_MARK_STEP:    r_mark_step    <= i_cfg.data[STEP_W-1:0];
                REG_FRAGMENT_LEN: r_fragment_len <= i_cfg.data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_shifter  <= '0;
            r_bits_rem <= '0;
            r_sib      <= '0;
        end else if (o_push) begin
            r_phase    <= n_phase;
            r_shifter  <= n_shifter;
            r_bits_rem <= n_bits_rem;
            r_sib      <= n_sib;
        end
    end

endmodule

FILE: hw/rtl/fskm_fifo.sv
// Short work queue between the front and back parts.
module fskm_fifo
    import fskm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_work o_work
);

    t_work                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_PTR_W:0]   r_count;

    assign o_full  = (r_count == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_work  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (FIFO_PTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (FIFO_PTR_W+1)'(1);
            end
        end
    end

endmodule

FILE: hw/rtl/fskm_back.sv
// Back part: quarter-wave sine lookup and the registered result stage.
module fskm_back
    import fskm_pkg::*;
#(
    parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_empty,
    input  t_work    i_work,
    output logic     o_pop,
    fskm_out_if.source o_out
);

    localparam int QUARTER_BITS = SINE_ADDR_BITS - 2;
    localparam int QSIZE        = 1 << QUARTER_BITS;
    localparam logic [MAG_W-1:0] ROM_TOP = rom_value(QSIZE, QUARTER_BITS);

    logic [MAG_W-1:0]        w_rom [QSIZE];
    logic [1:0]              w_quad;
    logic [QUARTER_BITS-1:0] w_k;
    logic [MAG_W-1:0]        w_mag;
    logic [SAMPLE_W-1:0]     w_sample;

    logic                r_valid;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_sample_valid;
    logic                r_accepted;
    logic                r_need_byte;

    for (genvar g = 0; g < QSIZE; g++) begin : g_rom
        assign w_rom[g] = rom_value(g, QUARTER_BITS);
    end

    assign w_quad = i_work.addr[SINE_ADDR_BITS-1 -: 2];
    assign w_k    = i_work.addr[QUARTER_BITS-1:0];

    always_comb begin
        if (!w_quad[0]) begin
            w_mag = w_rom[w_k];
        end else if (w_k == '0) begin
            w_mag = ROM_TOP;
        end else begin
            w_mag = w_rom[QUARTER_BITS'(0) - w_k];
        end
        if (!i_work.active) begin
            w_sample = '0;
        end else if (w_quad[1]) begin
            w_sample = SAMPLE_W'(0) - {1'b0, w_mag};
        end else begin
            w_sample = {1'b0, w_mag};
        end
    end

    assign o_pop = !i_empty && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sample       <= w_sample;
            r_sample_valid <= i_work.active;
            r_accepted     <= i_work.accepted;
            r_need_byte    <= i_work.need_byte;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.sample        = $signed(r_sample);
    assign o_out.sample_valid  = r_sample_valid;
    assign o_out.byte_accepted = r_accepted;
    assign o_out.need_byte     = r_need_byte;

endmodule

FILE: hw/rtl/binary_fsk_tone_modulator.sv
// Top level of the phase-continuous binary FSK tone modulator.
// Usage: i_in carries one item per handshake: cmd selects a byte load or a sample
// tick, data_byte holds the byte for a load. Every item gives exactly one result
// item on o_out: a tone sample with sample_valid for an active tick, byte_accepted
// for a load taken while no bits remained, and need_byte after the item.
// i_cfg writes space_step (index 0), mark_step (index 1) and fragment_len
// (index 2); it is always ready. The user must write it only while the block
// is idle; the block itself does not enforce this. An accepted item is written
// into the four-entry queue, then the back reads the sine table for it and
// registers the result when the item is popped.
// Throughput: one item per cycle while the queue is not full.
// Reset: configuration returns to its defaults, phase and bit state clear to
// zero, and the queue and result register empty.
// Receiver stall: the result register holds, the queue absorbs up to four items,
// and i_in.ready falls once the queue is full.
module binary_fsk_tone_modulator
    import fskm_pkg::*;
#(
    parameter int PHASE_BITS     = PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fskm_in_if.sink    i_in,
    fskm_cfg_if.sink   i_cfg,
    fskm_out_if.source o_out
);

    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;
    t_work w_front_work;
    t_work w_back_work;

    fskm_front #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_work  (w_front_work)
    );

    fskm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_work  (w_front_work),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_work  (w_back_work)
    );

    fskm_back #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_work  (w_back_work),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
